>>> src/bezier_step_trajectory_assert.svh
// Assertion macros for the foot trajectory generator.
// Every module that uses them has ports clk_i and rst_ni.
`ifndef BEZIER_STEP_TRAJECTORY_ASSERT_SVH
`define BEZIER_STEP_TRAJECTORY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bst_pkg.sv
// Shared types and constants of the foot trajectory generator:
// microcode word layout, step program, movement and register codes.
// No dependencies.
package bst_pkg;

  // Movement codes
  localparam logic [2:0] MV_NONE  = 3'd0;
  localparam logic [2:0] MV_FWD   = 3'd1;
  localparam logic [2:0] MV_BACK  = 3'd2;
  localparam logic [2:0] MV_RIGHT = 3'd3;
  localparam logic [2:0] MV_LEFT  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_HOME_X  = 3'd0;
  localparam logic [2:0] REG_HOME_Y  = 3'd1;
  localparam logic [2:0] REG_HOME_Z  = 3'd2;
  localparam logic [2:0] REG_LIFT    = 3'd3;
  localparam logic [2:0] REG_FWD     = 3'd4;
  localparam logic [2:0] REG_SIDE    = 3'd5;
  localparam logic [2:0] REG_INC     = 3'd6;

  // Register reset values
  localparam logic signed [18:0] HOME_X_RST = -19'sd42000;
  localparam logic signed [18:0] HOME_Y_RST = -19'sd111567;
  localparam logic signed [18:0] HOME_Z_RST = 19'sd0;
  localparam logic [16:0]        LIFT_RST   = 17'd50000;
  localparam logic [16:0]        FWD_RST    = 17'd100000;
  localparam logic [16:0]        SIDE_RST   = 17'd50000;
  localparam logic [15:0]        INC_RST    = 16'd3641;

  // Last axis index (x, y, z)
  localparam logic [1:0] AXIS_LAST = 2'd2;

  // Multiplier operand selects
  typedef enum logic [2:0] {A_U, A_T, A_UU, A_TT, A_W} asel_e;
  typedef enum logic [1:0] {B_U, B_T, B_PT} bsel_e;
  // Write-back of the rounded product
  typedef enum logic [1:0] {WB_NONE, WB_UU, WB_TT, WB_W} wb_e;
  // Accumulator operation on the registered product
  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_ADD3} acc_e;
  // Sequencer flow
  typedef enum logic [1:0] {J_NEXT, J_AXIS, J_END} jmp_e;

  typedef struct packed {
    asel_e      a;
    bsel_e      b;
    wb_e        wb;
    acc_e       acc;
    logic [1:0] pt;    // control point / weight index
    logic       st;    // store rounded sum to the current axis
    jmp_e       jmp;
  } ucode_t;

  typedef struct packed {
    logic       run;
    ucode_t     uc;
    logic [1:0] axis;
  } ctrl_t;

  // Step addresses
  localparam logic [3:0] S_UU  = 4'd0;
  localparam logic [3:0] S_TT  = 4'd1;
  localparam logic [3:0] S_W0  = 4'd2;
  localparam logic [3:0] S_W1  = 4'd3;
  localparam logic [3:0] S_W2  = 4'd4;
  localparam logic [3:0] S_W3  = 4'd5;
  localparam logic [3:0] S_WL  = 4'd6;
  localparam logic [3:0] S_P0  = 4'd7;
  localparam logic [3:0] S_P1  = 4'd8;
  localparam logic [3:0] S_P2  = 4'd9;
  localparam logic [3:0] S_P3  = 4'd10;
  localparam logic [3:0] S_SUM = 4'd11;
  localparam logic [3:0] S_ST  = 4'd12;
  localparam logic [3:0] S_END = 4'd13;

  localparam ucode_t UC_NOP = '{a: A_U, b: B_U, wb: WB_NONE, acc: ACC_NONE,
                                pt: 2'd0, st: 1'b0, jmp: J_NEXT};

  // Control store. Products are held in the product register for the next step,
  // so each write-back or accumulate consumes the previous step's product.
  function automatic ucode_t bst_ucode(input logic [3:0] s);
    ucode_t w;
    w = UC_NOP;
    unique case (s)
      S_UU:  begin w.a = A_U;  w.b = B_U; end
      S_TT:  begin w.a = A_T;  w.b = B_T; w.wb = WB_UU; end
      S_W0:  begin w.a = A_UU; w.b = B_U; w.wb = WB_TT; end
      S_W1:  begin w.a = A_UU; w.b = B_T; w.wb = WB_W; w.pt = 2'd0; end
      S_W2:  begin w.a = A_TT; w.b = B_U; w.wb = WB_W; w.pt = 2'd1; end
      S_W3:  begin w.a = A_TT; w.b = B_T; w.wb = WB_W; w.pt = 2'd2; end
      S_WL:  begin w.wb = WB_W; w.pt = 2'd3; end
      S_P0:  begin w.a = A_W; w.b = B_PT; w.pt = 2'd0; end
      S_P1:  begin w.a = A_W; w.b = B_PT; w.pt = 2'd1; w.acc = ACC_LOAD; end
      S_P2:  begin w.a = A_W; w.b = B_PT; w.pt = 2'd2; w.acc = ACC_ADD3; end
      S_P3:  begin w.a = A_W; w.b = B_PT; w.pt = 2'd3; w.acc = ACC_ADD3; end
      S_SUM: begin w.acc = ACC_ADD; end
      S_ST:  begin w.st = 1'b1; w.jmp = J_AXIS; end
      S_END: begin w.jmp = J_END; end
      default: begin w.jmp = J_END; end
    endcase
    return w;
  endfunction

endpackage

>>> src/bst_seq.sv
// Microcode sequencer: step counter, axis loop counter and control store.
// Depends on bst_pkg and bezier_step_trajectory_assert.svh.
`include "bezier_step_trajectory_assert.svh"

module bst_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,     // begin a tick program
  input  logic           out_free_i,  // output register can take a result
  output bst_pkg::ctrl_t ctrl_o,
  output logic           busy_o,
  output logic           fin_o        // result ready to register this cycle
);

  logic                busy_q, busy_d;
  logic [3:0]          step_q, step_d;
  logic [1:0]          axis_q, axis_d;
  bst_pkg::ucode_t     uc;

  // Fetch
  always_comb begin
    uc = bst_pkg::bst_ucode(step_q);
  end

  assign fin_o  = busy_q && (uc.jmp == bst_pkg::J_END) && out_free_i;
  assign busy_o = busy_q;

  always_comb begin
    ctrl_o.run  = busy_q;
    ctrl_o.uc   = uc;
    ctrl_o.axis = axis_q;
  end

  // Next step
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    axis_d = axis_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = bst_pkg::S_UU;
      axis_d = 2'd0;
    end else if (busy_q) begin
      unique case (uc.jmp)
        bst_pkg::J_NEXT: step_d = step_q + 4'd1;
        bst_pkg::J_AXIS: begin
          if (axis_q == bst_pkg::AXIS_LAST) begin
            step_d = step_q + 4'd1;
          end else begin
            axis_d = axis_q + 2'd1;
            step_d = bst_pkg::S_P0;
          end
        end
        bst_pkg::J_END: begin
          if (out_free_i) begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= bst_pkg::S_UU;
      axis_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      axis_q <= axis_d;
    end
  end

  // Checks
  `BST_ASSERT_NOW(a_no_start_busy, start_i, !busy_q, "tick started while program running")
  `BST_ASSERT_NEXT(a_axis_exit, busy_q && step_q == bst_pkg::S_ST && axis_q == bst_pkg::AXIS_LAST && !start_i, step_q == bst_pkg::S_END, "axis loop did not exit after z")
  `BST_ASSERT_NEXT(a_stay_busy, busy_q && step_q != bst_pkg::S_END, busy_q, "program ended before its last step")
  `BST_ASSERT_NOW(a_step_range, busy_q, step_q <= bst_pkg::S_END, "step counter outside program")

endmodule

>>> src/bst_datapath.sv
// Datapath under microcode control: one shared multiplier with product
// register, weight registers, accumulator and per-axis result registers.
// Depends on bst_pkg.
module bst_datapath #(
  parameter int POS_BITS  = 19,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  bst_pkg::ctrl_t                      ctrl_i,
  input  logic                                start_i,  // load phase t
  input  logic [FRAC_BITS:0]                  t_i,
  input  logic signed [POS_BITS-1:0]          pt_val_i, // selected control point
  output logic [2:0][POS_BITS-1:0]            pos_o
);

  localparam int BW = (POS_BITS > FRAC_BITS + 2) ? POS_BITS : FRAC_BITS + 2;
  localparam int PW = FRAC_BITS + 2 + BW;
  localparam int AW = PW + 3;
  localparam logic [FRAC_BITS:0]       ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [2*FRAC_BITS+1:0]   HALF_R = (2*FRAC_BITS+2)'(64'd1 << (FRAC_BITS-1));
  localparam logic signed [AW-1:0]     HALF_A = AW'(64'sd1 <<< (FRAC_BITS-1));
  localparam longint                   PMAX_L = (64'sd1 <<< (POS_BITS-1)) - 64'sd1;
  localparam logic signed [AW-1:0]     PMAX_A = AW'(PMAX_L);
  localparam logic signed [AW-1:0]     PMIN_A = AW'(-PMAX_L - 64'sd1);

  logic [FRAC_BITS:0]          t_q, u_q, uu_q, tt_q;
  logic [3:0][FRAC_BITS:0]     w_q;
  logic signed [PW-1:0]        prod_q, prod_d;
  logic signed [AW-1:0]        acc_q, acc_d;
  logic [2:0][POS_BITS-1:0]    pos_q;

  logic [FRAC_BITS:0]          a_op;
  logic signed [BW-1:0]        b_op;
  logic [2*FRAC_BITS+1:0]      rsum;
  logic [FRAC_BITS:0]          rnd_val;
  logic signed [AW-1:0]        prod_ext, sh;
  logic [POS_BITS-1:0]         sat_val;

  // Operand select
  always_comb begin
    case (ctrl_i.uc.a)
      bst_pkg::A_U:  a_op = u_q;
      bst_pkg::A_T:  a_op = t_q;
      bst_pkg::A_UU: a_op = uu_q;
      bst_pkg::A_TT: a_op = tt_q;
      bst_pkg::A_W:  a_op = w_q[ctrl_i.uc.pt];
      default:       a_op = '0;
    endcase
    case (ctrl_i.uc.b)
      bst_pkg::B_U:  b_op = signed'(BW'(u_q));
      bst_pkg::B_T:  b_op = signed'(BW'(t_q));
      bst_pkg::B_PT: b_op = BW'(pt_val_i);
      default:       b_op = '0;
    endcase
  end

  // Shared multiplier
  assign prod_d = signed'({1'b0, a_op}) * b_op;

  // Rounded Q1.F product for the weight chain (non-negative there)
  assign rsum    = prod_q[2*FRAC_BITS+1:0] + HALF_R;
  assign rnd_val = rsum[2*FRAC_BITS:FRAC_BITS];

  // Accumulator
  assign prod_ext = AW'(prod_q);
  always_comb begin
    case (ctrl_i.uc.acc)
      bst_pkg::ACC_LOAD: acc_d = prod_ext;
      bst_pkg::ACC_ADD:  acc_d = acc_q + prod_ext;
      bst_pkg::ACC_ADD3: acc_d = acc_q + (prod_ext <<< 1) + prod_ext;
      default:           acc_d = acc_q;
    endcase
  end

  // Round to micrometres (floor of sum plus half) and saturate
  assign sh = (acc_q + HALF_A) >>> FRAC_BITS;
  always_comb begin
    if (sh > PMAX_A) begin
      sat_val = POS_BITS'(PMAX_A);
    end else if (sh < PMIN_A) begin
      sat_val = POS_BITS'(PMIN_A);
    end else begin
      sat_val = sh[POS_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      t_q <= t_i;
      u_q <= ONE_Q - t_i;
    end
    if (ctrl_i.run) begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
      case (ctrl_i.uc.wb)
        bst_pkg::WB_UU: uu_q <= rnd_val;
        bst_pkg::WB_TT: tt_q <= rnd_val;
        bst_pkg::WB_W:  w_q[ctrl_i.uc.pt] <= rnd_val;
        default: ;
      endcase
      if (ctrl_i.uc.st) begin
        pos_q[ctrl_i.axis] <= sat_val;
      end
    end
  end

  assign pos_o = pos_q;

endmodule

>>> src/bezier_step_trajectory.sv
// Foot trajectory generator, top level: stream ports, configuration registers,
// progress counter, control points; instantiates bst_seq and bst_datapath.
// Depends on bst_pkg.
//
// Item on the input: tuser is func (0 tick, 1 command), tdata[2:0] the movement.
// A command loads the control points in the cycle it is accepted and gives no
// result. A tick advances progress and runs a 26-step microcode program on one
// shared multiplier (six products for the Bezier weights, then four products
// per axis), and no further item is taken until that program has ended. The
// result of the tick that ends the path carries tlast. The output register lets
// the next item enter while a result still waits; a program only stalls at its
// last step if the previous result has not been taken.
module bezier_step_trajectory #(
  parameter int POS_BITS  = 19,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input items
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [2:0] movement, zero above
  input  logic         s_axis_tuser_i,   // [0] func
  // result items
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pos_x, pos_y, pos_z, second_half, moving, active_movement,
  // zero padded to whole bytes
  output logic [((3*POS_BITS+5+7)/8)*8-1:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,   // path_done
  // configuration
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [18:0]  cfg_data_i
);

  localparam int PROG   = FRAC_BITS + 2;
  localparam int OW     = ((3*POS_BITS + 5 + 7) / 8) * 8;
  localparam int INC_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int INC_DN = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam int IW     = 16 + INC_UP;
  localparam int CW     = ((POS_BITS > 21) ? POS_BITS : 21) + 1;
  localparam logic [PROG-1:0] HALF_TH =
    PROG'(((64'd11 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [PROG-1:0] END_TH  =
    PROG'(2 * (((64'd11 << FRAC_BITS) + 64'd5) / 64'd10));
  localparam logic [PROG-1:0] ONE_P   = PROG'(64'd1 << FRAC_BITS);
  localparam longint               PMAX_L = (64'sd1 <<< (POS_BITS-1)) - 64'sd1;
  localparam logic signed [CW-1:0] PMAX_C = CW'(PMAX_L);
  localparam logic signed [CW-1:0] PMIN_C = CW'(-PMAX_L - 64'sd1);

  // Saturate a loaded point to the position range
  function automatic logic [POS_BITS-1:0] sat_pt(input logic signed [20:0] v);
    logic signed [CW-1:0] ve;
    ve = CW'(v);
    if (ve > PMAX_C) begin
      return POS_BITS'(PMAX_C);
    end else if (ve < PMIN_C) begin
      return POS_BITS'(PMIN_C);
    end
    return ve[POS_BITS-1:0];
  endfunction

  // Configuration registers
  logic signed [18:0] home_x_q, home_y_q, home_z_q;
  logic [16:0]        lift_q, fwd_q, side_q;
  logic [15:0]        inc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_x_q <= bst_pkg::HOME_X_RST;
      home_y_q <= bst_pkg::HOME_Y_RST;
      home_z_q <= bst_pkg::HOME_Z_RST;
      lift_q   <= bst_pkg::LIFT_RST;
      fwd_q    <= bst_pkg::FWD_RST;
      side_q   <= bst_pkg::SIDE_RST;
      inc_q    <= bst_pkg::INC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bst_pkg::REG_HOME_X: home_x_q <= cfg_data_i;
        bst_pkg::REG_HOME_Y: home_y_q <= cfg_data_i;
        bst_pkg::REG_HOME_Z: home_z_q <= cfg_data_i;
        bst_pkg::REG_LIFT:   lift_q   <= cfg_data_i[16:0];
        bst_pkg::REG_FWD:    fwd_q    <= cfg_data_i[16:0];
        bst_pkg::REG_SIDE:   side_q   <= cfg_data_i[16:0];
        bst_pkg::REG_INC:    inc_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic           busy, fin, out_free;
  logic           acc_in, tick, cmd;
  logic [2:0]     mv_in;
  bst_pkg::ctrl_t ctrl;

  assign s_axis_tready_o = !busy;
  assign acc_in   = s_axis_tvalid_i && s_axis_tready_o;
  assign tick     = acc_in && !s_axis_tuser_i;
  assign cmd      = acc_in && s_axis_tuser_i;
  assign mv_in    = s_axis_tdata_i[2:0];
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  // Progress and phase
  logic [PROG-1:0]    progress_q, prog_n, t_full;
  logic [IW-1:0]      inc_ext;
  logic [FRAC_BITS:0] t_val;

  assign inc_ext = IW'(inc_q) << INC_UP;
  assign prog_n  = progress_q + PROG'(inc_ext >> INC_DN);
  assign t_full  = (prog_n <= HALF_TH) ? prog_n : prog_n - HALF_TH;
  assign t_val   = (t_full > ONE_P) ? ONE_P[FRAC_BITS:0] : t_full[FRAC_BITS:0];

  // Movement state and per-tick flags
  logic        active_q, half_q, moving_q, done_q;
  logic [2:0]  cur_mv_q, mv_out_q;
  logic [3:0][2:0][POS_BITS-1:0] pts_q;

  logic signed [20:0] hx, hy, hz;
  logic [POS_BITS-1:0] px, py, pz, py_lift, pz_fwd, pz_back, px_side;
  logic                mv_ok;

  assign hx = 21'(home_x_q);
  assign hy = 21'(home_y_q);
  assign hz = 21'(home_z_q);
  assign px      = sat_pt(hx);
  assign py      = sat_pt(hy);
  assign pz      = sat_pt(hz);
  assign py_lift = sat_pt(hy + signed'(21'(lift_q)));
  assign pz_fwd  = sat_pt(hz - signed'(21'(fwd_q)));
  assign pz_back = sat_pt(hz + signed'(21'(fwd_q)));
  assign px_side = sat_pt(hx - signed'(21'(side_q)));
  assign mv_ok   = (mv_in == bst_pkg::MV_FWD) || (mv_in == bst_pkg::MV_BACK) ||
                   (mv_in == bst_pkg::MV_RIGHT) || (mv_in == bst_pkg::MV_LEFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      progress_q <= '0;
      active_q   <= 1'b0;
      cur_mv_q   <= bst_pkg::MV_NONE;
      pts_q      <= '0;
      half_q     <= 1'b0;
      moving_q   <= 1'b0;
      done_q     <= 1'b0;
      mv_out_q   <= bst_pkg::MV_NONE;
    end else if (cmd) begin
      // Command: load points
      progress_q <= '0;
      if (mv_ok) begin
        active_q <= 1'b1;
        cur_mv_q <= mv_in;
        for (int p = 0; p < 4; p++) begin
          pts_q[p][0] <= px;
          pts_q[p][1] <= py;
          pts_q[p][2] <= pz;
        end
        pts_q[1][1] <= py_lift;
        pts_q[2][1] <= py_lift;
        case (mv_in) inside
          bst_pkg::MV_FWD: begin
            pts_q[2][2] <= pz_fwd;
            pts_q[3][2] <= pz_fwd;
          end
          bst_pkg::MV_BACK: begin
            pts_q[2][2] <= pz_back;
            pts_q[3][2] <= pz_back;
          end
          bst_pkg::MV_RIGHT, bst_pkg::MV_LEFT: begin
            pts_q[2][0] <= px_side;
            pts_q[3][0] <= px_side;
          end
          default: ;
        endcase
      end else begin
        active_q <= 1'b0;
        cur_mv_q <= bst_pkg::MV_NONE;
        pts_q    <= '0;
      end
    end else if (tick) begin
      // Tick: advance progress, capture flags for the result
      progress_q <= (prog_n >= END_TH) ? '0 : prog_n;
      half_q     <= prog_n > HALF_TH;
      moving_q   <= active_q;
      done_q     <= prog_n >= END_TH;
      mv_out_q   <= cur_mv_q;
    end else if (fin && done_q) begin
      // End of path: back to idle once this result is in the output register
      active_q <= 1'b0;
      cur_mv_q <= bst_pkg::MV_NONE;
      pts_q    <= '0;
    end
  end

  // Sequencer and datapath
  logic [2:0][POS_BITS-1:0] pos;
  logic signed [POS_BITS-1:0] pt_val;

  assign pt_val = pts_q[ctrl.uc.pt][ctrl.axis];

  bst_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (tick),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .fin_o      (fin)
  );

  bst_datapath #(
    .POS_BITS  (POS_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .start_i  (tick),
    .t_i      (t_val),
    .pt_val_i (pt_val),
    .pos_o    (pos)
  );

  // Output register
  logic          out_vld_q;
  logic [OW-1:0] out_data_q;
  logic          out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_data_q <= OW'({mv_out_q, moving_q, half_q, pos[2], pos[1], pos[0]});
      out_last_q <= done_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> verif/bezier_step_trajectory_tb.sv
// Self-checking testbench for the foot trajectory generator.
// Needs bst_pkg and bezier_step_trajectory; an in-bench predictor checks every point.
module bezier_step_trajectory_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_BITS    = 19;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = ((3 * POS_BITS + 5 + 7) / 8) * 8;
  localparam longint ONE_Q   = 64'd1 << FRAC_BITS;
  localparam longint HALF_Q  = 64'd1 << (FRAC_BITS - 1);
  localparam longint HALF_THR = ((64'd11 << FRAC_BITS) + 5) / 10;
  localparam longint END_THR  = 2 * HALF_THR;
  localparam longint PROG_MASK = (64'd1 << (FRAC_BITS + 2)) - 1;
  localparam longint POS_MAX = (64'd1 << (POS_BITS - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;

  localparam logic       FN_TICK = 1'b0;
  localparam logic       FN_CMD  = 1'b1;
  // movement codes the block treats as "stop"
  localparam logic [2:0] MV_BAD_LO  = 3'd5;
  localparam logic [2:0] MV_BAD_MID = 3'd6;
  localparam logic [2:0] MV_BAD_HI  = 3'd7;
  // an index with no register behind it
  localparam logic [2:0] REG_VOID = 3'd7;

  localparam int SETTLE_CYCLES = 40;    // a little over one tick program
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int PATH_CAP      = 60;

  typedef struct packed {
    logic signed [POS_BITS-1:0] px;
    logic signed [POS_BITS-1:0] py;
    logic signed [POS_BITS-1:0] pz;
    logic                       sh;
    logic                       mov;
    logic                       done;
    logic [2:0]                 amv;
  } foot_pt_t;

  typedef struct packed {
    logic       fn;
    logic [2:0] mv;
    logic       typed;
    foot_pt_t   pt;
  } script_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_e;

  // point emitted by an idle generator with cleared control points
  localparam foot_pt_t ORIGIN = '{px: '0, py: '0, pz: '0, sh: 1'b0, mov: 1'b0,
                                  done: 1'b0, amv: bst_pkg::MV_NONE};

  localparam int SCRIPT_N = 20;
  localparam script_row_t SCRIPT [SCRIPT_N] = '{
    '{FN_TICK, bst_pkg::MV_NONE,  1'b1, ORIGIN},   // tick straight out of reset
    '{FN_CMD,  bst_pkg::MV_NONE,  1'b0, ORIGIN},   // explicit stop
    '{FN_TICK, bst_pkg::MV_NONE,  1'b1, ORIGIN},
    '{FN_CMD,  bst_pkg::MV_FWD,   1'b0, ORIGIN},
    '{FN_TICK, bst_pkg::MV_NONE,  1'b0, ORIGIN},
    '{FN_TICK, bst_pkg::MV_NONE,  1'b0, ORIGIN},
    '{FN_CMD,  bst_pkg::MV_BACK,  1'b0, ORIGIN},
    '{FN_TICK, bst_pkg::MV_NONE,  1'b0, ORIGIN},
    '{FN_CMD,  bst_pkg::MV_RIGHT, 1'b0, ORIGIN},
    '{FN_TICK, bst_pkg::MV_NONE,  1'b0, ORIGIN},
    '{FN_CMD,  bst_pkg::MV_LEFT,  1'b0, ORIGIN},
    '{FN_TICK, bst_pkg::MV_NONE,  1'b0, ORIGIN},
    '{FN_TICK, MV_BAD_HI,         1'b0, ORIGIN},   // movement bits ignored on a tick
    '{FN_CMD,  MV_BAD_LO,         1'b0, ORIGIN},   // unknown code idles
    '{FN_TICK, bst_pkg::MV_NONE,  1'b1, ORIGIN},
    '{FN_CMD,  MV_BAD_MID,        1'b0, ORIGIN},
    '{FN_CMD,  MV_BAD_HI,         1'b0, ORIGIN},
    '{FN_TICK, bst_pkg::MV_NONE,  1'b1, ORIGIN},
    '{FN_CMD,  bst_pkg::MV_FWD,   1'b0, ORIGIN},
    '{FN_TICK, bst_pkg::MV_NONE,  1'b0, ORIGIN}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i = '0;   // [2:0] movement, zero above
  logic             s_axis_tuser_i = 1'b0; // [0] func
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  // pos_x, pos_y, pos_z, second_half, moving, active_movement
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             m_axis_tlast_o;        // path_done
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_idx_i = '0;
  logic [18:0]      cfg_data_i = '0;

  bezier_step_trajectory u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // Trajectory predictor: registers, progress, control points
  // ---------------------------------------------------------------------
  longint     cfg_home_x = bst_pkg::HOME_X_RST;
  longint     cfg_home_y = bst_pkg::HOME_Y_RST;
  longint     cfg_home_z = bst_pkg::HOME_Z_RST;
  longint     cfg_lift   = bst_pkg::LIFT_RST;
  longint     cfg_fwd    = bst_pkg::FWD_RST;
  longint     cfg_side   = bst_pkg::SIDE_RST;
  longint     cfg_inc    = bst_pkg::INC_RST;
  longint     track_prog = 0;
  longint     track_pts [12];
  bit         track_active = 1'b0;
  logic [2:0] track_mv = bst_pkg::MV_NONE;

  foot_pt_t   pending_feet [$];

  int n_ticks, n_cmds, n_checked, n_errors, n_settings, n_holds, n_drains;
  int burst_left;
  bit hold_req;

  initial foreach (track_pts[i]) track_pts[i] = 0;

  function automatic longint sat_pos(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic longint q_round(input longint a);
    return (a + HALF_Q) >>> FRAC_BITS;
  endfunction

  function automatic void clear_points();
    foreach (track_pts[i]) track_pts[i] = 0;
  endfunction

  // one axis of the cubic, weights rounded as the datapath rounds them
  function automatic longint bezier_axis(input int axis, input longint t);
    longint u, uu, tt, w0, w1, w2, w3, s;
    u  = ONE_Q - t;
    uu = q_round(u * u);
    tt = q_round(t * t);
    w0 = q_round(uu * u);
    w1 = 3 * q_round(uu * t);
    w2 = 3 * q_round(tt * u);
    w3 = q_round(tt * t);
    s  = w0 * track_pts[axis] + w1 * track_pts[3 + axis]
       + w2 * track_pts[6 + axis] + w3 * track_pts[9 + axis] + HALF_Q;
    return sat_pos(s >>> FRAC_BITS);
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [18:0] d);
    case (idx)
      bst_pkg::REG_HOME_X: cfg_home_x = longint'(signed'(d));
      bst_pkg::REG_HOME_Y: cfg_home_y = longint'(signed'(d));
      bst_pkg::REG_HOME_Z: cfg_home_z = longint'(signed'(d));
      bst_pkg::REG_LIFT:   cfg_lift   = longint'(d[16:0]);
      bst_pkg::REG_FWD:    cfg_fwd    = longint'(d[16:0]);
      bst_pkg::REG_SIDE:   cfg_side   = longint'(d[16:0]);
      bst_pkg::REG_INC:    cfg_inc    = longint'(d[15:0]);
      default: ;
    endcase
  endfunction

  // command: rebuild the four control points around home, or clear them for an unknown code
  function automatic void load_move(input logic [2:0] mv);
    track_prog = 0;
    if (mv < bst_pkg::MV_FWD || mv > bst_pkg::MV_LEFT) begin
      track_active = 1'b0;
      track_mv     = bst_pkg::MV_NONE;
      clear_points();
      return;
    end
    for (int p = 0; p < 4; p++) begin
      track_pts[p * 3]     = sat_pos(cfg_home_x);
      track_pts[p * 3 + 1] = sat_pos(cfg_home_y);
      track_pts[p * 3 + 2] = sat_pos(cfg_home_z);
    end
    track_pts[4] = sat_pos(cfg_home_y + cfg_lift);
    track_pts[7] = track_pts[4];
    case (mv)
      bst_pkg::MV_FWD: begin
        track_pts[8]  = sat_pos(cfg_home_z - cfg_fwd);
        track_pts[11] = track_pts[8];
      end
      bst_pkg::MV_BACK: begin
        track_pts[8]  = sat_pos(cfg_home_z + cfg_fwd);
        track_pts[11] = track_pts[8];
      end
      default: begin  // right and left shift x the same way
        track_pts[6] = sat_pos(cfg_home_x - cfg_side);
        track_pts[9] = track_pts[6];
      end
    endcase
    track_active = 1'b1;
    track_mv     = mv;
  endfunction

  // tick: advance progress, evaluate the curve, retire the path at its end
  function automatic foot_pt_t predict_tick();
    foot_pt_t r;
    longint   t;
    track_prog = (track_prog + cfg_inc) & PROG_MASK;
    t = (track_prog <= HALF_THR) ? track_prog : track_prog - HALF_THR;
    if (t > ONE_Q) t = ONE_Q;
    r.px   = POS_BITS'(bezier_axis(0, t));
    r.py   = POS_BITS'(bezier_axis(1, t));
    r.pz   = POS_BITS'(bezier_axis(2, t));
    r.sh   = track_prog > HALF_THR;
    r.mov  = track_active;
    r.done = track_prog >= END_THR;
    r.amv  = track_mv;
    if (r.done) begin
      track_active = 1'b0;
      track_prog   = 0;
      track_mv     = bst_pkg::MV_NONE;
      clear_points();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of items with random gaps
  // ---------------------------------------------------------------------
  task automatic send_item(input logic fn, input logic [2:0] mv, input bit typed,
                           input foot_pt_t typed_pt);
    foot_pt_t pt;
    if (burst_left == 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= fn;
    s_axis_tdata_i  <= {5'b0, mv};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
    if (fn == FN_CMD) begin
      load_move(mv);
      n_cmds++;
    end else begin
      pt = predict_tick();
      pending_feet.push_back(typed ? typed_pt : pt);
      n_ticks++;
    end
  endtask

  // drop valid and let every outstanding point come back
  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (pending_feet.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [18:0] d);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    apply_reg(idx, d);
  endtask

  task automatic set_config(input logic [18:0] hx, input logic [18:0] hy,
                            input logic [18:0] hz, input logic [18:0] lift,
                            input logic [18:0] fwd, input logic [18:0] side,
                            input logic [18:0] inc);
    quiesce();
    write_reg(bst_pkg::REG_HOME_X, hx);
    write_reg(bst_pkg::REG_HOME_Y, hy);
    write_reg(bst_pkg::REG_HOME_Z, hz);
    write_reg(bst_pkg::REG_LIFT, lift);
    write_reg(bst_pkg::REG_FWD, fwd);
    write_reg(bst_pkg::REG_SIDE, side);
    write_reg(bst_pkg::REG_INC, inc);
    write_reg(REG_VOID, 19'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // mostly whole steps (command then ticks), some cut short or overrun into
  // idle, plus a share of raw noise items
  task automatic run_phase(input int n_items, input bit with_hold, input bit with_pause);
    int  sent, len, nt;
    bit  mid_done;
    sent = 0;
    mid_done = 1'b0;
    while (sent < n_items) begin
      if (!mid_done && sent >= n_items / 2) begin
        mid_done = 1'b1;
        if (with_hold) hold_req = 1'b1;
        if (with_pause) begin
          quiesce();
          n_drains++;
        end
      end
      if ($urandom_range(0, 99) < 80) begin
        send_item(FN_CMD, 3'($urandom_range(bst_pkg::MV_FWD, bst_pkg::MV_LEFT)),
                  1'b0, ORIGIN);
        sent++;
        len = (cfg_inc == 0) ? PATH_CAP : int'((END_THR + cfg_inc - 1) / cfg_inc);
        if (len > PATH_CAP) len = PATH_CAP;
        case ($urandom_range(0, 3))
          0:       nt = $urandom_range(1, len);
          1:       nt = len + $urandom_range(1, len);
          default: nt = len;
        endcase
        for (int k = 0; k < nt && sent < n_items; k++) begin
          send_item(FN_TICK, 3'($urandom), 1'b0, ORIGIN);
          sent++;
        end
      end else begin
        nt = $urandom_range(1, 4);
        for (int k = 0; k < nt && sent < n_items; k++) begin
          send_item(1'($urandom), 3'($urandom), 1'b0, ORIGIN);
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus one long hold-off on request
  // ---------------------------------------------------------------------
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;

  always begin
    @(negedge clk_i);
    if (hold_req) begin
      m_axis_tready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_req = 1'b0;
      n_holds++;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   m_axis_tready_i <= 1'b1;
        RX_CHOPPY: m_axis_tready_i <= 1'($urandom);
        default:   m_axis_tready_i <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    foot_pt_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_feet.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected point, expected none actual %h", $time, m_axis_tdata_o);
      end else begin
        want = pending_feet.pop_front();
        n_checked++;
        report_field("pos_x", want.px, longint'(signed'(m_axis_tdata_o[18:0])));
        report_field("pos_y", want.py, longint'(signed'(m_axis_tdata_o[37:19])));
        report_field("pos_z", want.pz, longint'(signed'(m_axis_tdata_o[56:38])));
        report_field("second_half", want.sh, m_axis_tdata_o[57]);
        report_field("moving", want.mov, m_axis_tdata_o[58]);
        report_field("path_done", want.done, m_axis_tlast_o);
        report_field("active_movement", want.amv, m_axis_tdata_o[61:59]);
      end
    end
  end

  // watchdog on cycles without any accepted item
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("bezier_step_trajectory_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed walk under reset settings
    foreach (SCRIPT[i]) send_item(SCRIPT[i].fn, SCRIPT[i].mv, SCRIPT[i].typed, SCRIPT[i].pt);

    set_config(19'($urandom), 19'($urandom), 19'($urandom), 19'($urandom),
               19'($urandom), 19'($urandom), {3'($urandom), 16'($urandom_range(2000, 20000))});
    run_phase(240, 1'b1, 1'b0);

    // everything at its top value: saturation on lift and back, fastest path
    set_config(19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 19'h1FFFF, 19'h1FFFF, 19'h1FFFF, 19'h0FFFF);
    run_phase(200, 1'b0, 1'b1);

    // lowest x and z homes with full strides: saturation on the low side, slowest path
    set_config(19'h40000, 19'h3FFFF, 19'h40000, 19'h1FFFF, 19'h1FFFF, 19'h1FFFF, 19'h00001);
    run_phase(60, 1'b0, 1'b0);

    // zero increment holds progress; zero strides and lift
    set_config(19'h40000, 19'h40000, 19'h40000, 19'h0, 19'h0, 19'h0, 19'h0);
    run_phase(60, 1'b0, 1'b0);

    set_config(bst_pkg::HOME_X_RST, bst_pkg::HOME_Y_RST, bst_pkg::HOME_Z_RST,
               19'(bst_pkg::LIFT_RST), 19'(bst_pkg::FWD_RST),
               19'(bst_pkg::SIDE_RST), 19'h0FFFF);
    run_phase(100, 1'b0, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      set_config(19'($urandom), 19'($urandom), 19'($urandom), 19'($urandom),
                 19'($urandom), 19'($urandom),
                 {3'($urandom), 16'($urandom_range(400, 40000))});
      run_phase(200, ph == 2, ph == 4);
    end

    quiesce();

    $display("covered %0d ticks and %0d commands over %0d register settings, %0d points checked",
             n_ticks, n_cmds, n_settings, n_checked);
    $display("receiver held off %0d time(s), sender drained %0d time(s) mid-run",
             n_holds, n_drains);
    if (n_errors == 0) begin
      $display("bezier_step_trajectory_tb: PASS");
    end else begin
      $display("bezier_step_trajectory_tb: FAIL");
    end
    $finish;
  end

endmodule
